// ===== rtl/analog_axis_deadzone_curve_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the axis conditioning block
// Shared concurrent check forms; each use expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ANALOG_AXIS_DEADZONE_CURVE_CORE_MACROS_SVH
`define ANALOG_AXIS_DEADZONE_CURVE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AADC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define AADC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aadc_pkg.sv =====
// ---------------------------------------------------------------------------
// aadc_pkg
// Types, constants and the curve constant table of the axis conditioner.
// ---------------------------------------------------------------------------
package aadc_pkg;

    localparam int AXIS_COUNT = 16;

    // Item operation codes
    localparam logic OP_SET   = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    localparam int DIV_STEPS = 17;
    localparam int LOG_STEPS = 16;
    localparam int EXP_STEPS = 16;

    typedef logic [30:0] exp_tab_t [EXP_STEPS];

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_WRITE,
        DP_PASS,
        DP_ZERO,
        DP_SETUP,
        DP_DIV,
        DP_NORM,
        DP_LOG,
        DP_NLOG,
        DP_QMUL,
        DP_EXP,
        DP_CURVE,
        DP_SCALE
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] step;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op;
        logic analog;
        logic pass;
        logic dead;
        logic norm_done;
    } dp_status_t;

    // Integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bitv;
        res  = '0;
        rem  = v;
        bitv = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - res - bitv;
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q30 factors 2^(-2^-i), i = 1..16, by repeated square roots of one half
    function automatic exp_tab_t exp_consts();
        exp_tab_t    t;
        logic [63:0] c;
        c = isqrt64(64'd1 << 59);
        for (int i = 0; i < EXP_STEPS; i++)
        begin
            t[i] = c[30:0];
            c    = isqrt64(c << 30);
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_C = exp_consts();

endpackage

// ===== rtl/aadc_in_if.sv =====
// ---------------------------------------------------------------------------
// aadc_in_if
// Input item channel: set items and raw axis events.
// ---------------------------------------------------------------------------
interface aadc_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [3:0]         axis_id;
    logic               is_analog;
    logic signed [15:0] raw_value;
    logic [15:0]        deadzone_in;
    logic [15:0]        exponent_in;
    logic [15:0]        sensitivity_in;
    logic               invert_in;

    modport source (
        output valid, op, axis_id, is_analog, raw_value, deadzone_in,
               exponent_in, sensitivity_in, invert_in,
        input  ready
    );
    modport sink (
        input  valid, op, axis_id, is_analog, raw_value, deadzone_in,
               exponent_in, sensitivity_in, invert_in,
        output ready
    );
endinterface

// ===== rtl/aadc_out_if.sv =====
// ---------------------------------------------------------------------------
// aadc_out_if
// Result item channel: conditioned axis events.
// ---------------------------------------------------------------------------
interface aadc_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         axis_out;
    logic signed [15:0] raw_out;
    logic signed [23:0] conditioned_value;

    modport source (
        output valid, axis_out, raw_out, conditioned_value,
        input  ready
    );
    modport sink (
        input  valid, axis_out, raw_out, conditioned_value,
        output ready
    );
endinterface

// ===== rtl/aadc_dp.sv =====
// ---------------------------------------------------------------------------
// aadc_dp
// Bias table, divider, log/exp stepping and output register of the conditioner.
// ---------------------------------------------------------------------------
module aadc_dp
    import aadc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic               op,
    input  logic [3:0]         axis_id,
    input  logic               is_analog,
    input  logic signed [15:0] raw_value,
    input  logic [15:0]        deadzone_in,
    input  logic [15:0]        exponent_in,
    input  logic [15:0]        sensitivity_in,
    input  logic               invert_in,
    output logic [3:0]         axis_out,
    output logic signed [15:0] raw_out,
    output logic signed [23:0] conditioned_value
);

    // Latched item
    logic               op_reg;
    logic [3:0]         axis_reg;
    logic               analog_reg;
    logic signed [15:0] raw_reg;
    logic [15:0]        dz_in_reg;
    logic [15:0]        ex_in_reg;
    logic [15:0]        sens_in_reg;
    logic               inv_in_reg;

    // Bias table
    logic        bias_valid_reg [AXIS_COUNT];
    logic [15:0] bias_dz_reg    [AXIS_COUNT];
    logic [15:0] bias_ex_reg    [AXIS_COUNT];
    logic [15:0] bias_sens_reg  [AXIS_COUNT];
    logic        bias_inv_reg   [AXIS_COUNT];

    // Work registers
    logic [17:0] rem_reg;
    logic [16:0] den_reg;
    logic [17:0] x_reg;
    logic [4:0]  k_reg;
    logic [15:0] frac_reg;
    logic [20:0] nlog_reg;
    logic [24:0] qv_reg;
    logic [30:0] mexp_reg;
    logic [16:0] curve_reg;
    logic [23:0] result_reg;

    // Output register
    logic [3:0]  axis_out_reg;
    logic [15:0] raw_out_reg;
    logic [23:0] cond_out_reg;

    logic               in_range;
    logic [15:0]        dz;
    logic signed [16:0] v;
    logic               neg;
    logic [16:0]        absv;
    logic [16:0]        m;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod;
    logic [17:0]        sq;
    logic [8:0]         qi;
    logic [30:0]        shifted;
    logic [24:0]        mag;
    logic [24:0]        mag_sat;
    logic [24:0]        mag_neg;

    // Look up the entry and fold the sample
    always_comb
    begin
        in_range = int'(axis_reg) < AXIS_COUNT;
        dz       = bias_dz_reg[axis_reg];
        v        = bias_inv_reg[axis_reg] ? -17'(raw_reg) : 17'(raw_reg);
        neg      = v[16];
        absv     = neg ? 17'(-v) : 17'(v);
        m        = {absv[15:0], 1'b0};
    end

    assign status.op        = op_reg;
    assign status.analog    = analog_reg;
    assign status.pass      = !(in_range && bias_valid_reg[axis_reg]);
    assign status.dead      = m <= {1'b0, dz};
    assign status.norm_done = x_reg[16];

    // Select operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_LOG:
            begin
                mul_a = 32'(x_reg[16:0]);
                mul_b = 32'(x_reg[16:0]);
            end
            DP_QMUL:
            begin
                mul_a = 32'(bias_ex_reg[axis_reg]);
                mul_b = 32'(nlog_reg);
            end
            DP_EXP:
            begin
                mul_a = 32'(mexp_reg);
                mul_b = 32'(EXP_C[cmd.step[3:0]]);
            end
            DP_SCALE:
            begin
                mul_a = 32'(curve_reg);
                mul_b = 32'(bias_sens_reg[axis_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);
    assign sq   = prod[33:16];

    // Curve shift and output saturation
    always_comb
    begin
        qi      = qv_reg[24:16];
        shifted = mexp_reg >> (5'(qi) + 5'd14);
        mag     = prod[33:9];
        if (neg)
        begin
            mag_sat = (mag > 25'd8388608) ? 25'd8388608 : mag;
        end
        else
        begin
            mag_sat = (mag > 25'd8388607) ? 25'd8388607 : mag;
        end
        mag_neg = -mag_sat;
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LOAD)
        begin
            op_reg      <= op;
            axis_reg    <= axis_id;
            analog_reg  <= is_analog;
            raw_reg     <= raw_value;
            dz_in_reg   <= deadzone_in;
            ex_in_reg   <= exponent_in;
            sens_in_reg <= sensitivity_in;
            inv_in_reg  <= invert_in;
        end
    end

    // Entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXIS_COUNT; i++)
            begin
                bias_valid_reg[i] <= 1'b0;
            end
        end
        else if (cmd.op == DP_WRITE && in_range)
        begin
            bias_valid_reg[axis_reg] <= 1'b1;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_WRITE && in_range)
        begin
            bias_dz_reg[axis_reg]   <= dz_in_reg;
            bias_ex_reg[axis_reg]   <= ex_in_reg;
            bias_sens_reg[axis_reg] <= sens_in_reg;
            bias_inv_reg[axis_reg]  <= inv_in_reg;
        end
    end

    // Advance the arithmetic one step per command
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_PASS:
            begin
                result_reg <= 24'(raw_reg);
            end
            DP_ZERO:
            begin
                result_reg <= '0;
            end
            DP_SETUP:
            begin
                rem_reg  <= {1'b0, m - {1'b0, dz}};
                den_reg  <= 17'h10000 - {1'b0, dz};
                x_reg    <= '0;
                k_reg    <= '0;
                frac_reg <= '0;
            end
            DP_DIV:
            begin
                if (rem_reg >= {1'b0, den_reg})
                begin
                    rem_reg <= 18'(rem_reg - {1'b0, den_reg}) << 1;
                    x_reg   <= {x_reg[16:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_reg << 1;
                    x_reg   <= {x_reg[16:0], 1'b0};
                end
            end
            DP_NORM:
            begin
                x_reg <= x_reg << 1;
                k_reg <= k_reg + 5'd1;
            end
            DP_LOG:
            begin
                if (sq[17])
                begin
                    x_reg    <= sq >> 1;
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    x_reg    <= sq;
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            DP_NLOG:
            begin
                nlog_reg <= {k_reg, 16'h0000} - {5'd0, frac_reg};
            end
            DP_QMUL:
            begin
                qv_reg   <= prod[36:12];
                mexp_reg <= 31'h4000_0000;
            end
            DP_EXP:
            begin
                if (qv_reg[4'd15 - cmd.step[3:0]])
                begin
                    mexp_reg <= prod[60:30];
                end
            end
            DP_CURVE:
            begin
                curve_reg <= (qi >= 9'd17) ? 17'd0 : shifted[16:0];
            end
            DP_SCALE:
            begin
                result_reg <= neg ? mag_neg[23:0] : mag_sat[23:0];
            end
            default:
            begin
                result_reg <= result_reg;
            end
        endcase
    end

    // Hold the finished result for the receiver
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            axis_out_reg <= axis_reg;
            raw_out_reg  <= raw_reg;
            cond_out_reg <= result_reg;
        end
    end

    assign axis_out          = axis_out_reg;
    assign raw_out           = raw_out_reg;
    assign conditioned_value = cond_out_reg;

endmodule

// ===== rtl/aadc_ctrl.sv =====
// ---------------------------------------------------------------------------
// aadc_ctrl
// Sequencer of the conditioner: accepts items and steps the datapath.
// ---------------------------------------------------------------------------
`include "analog_axis_deadzone_curve_core_macros.svh"

module aadc_ctrl
    import aadc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_NORM,
        ST_LOG,
        ST_NLOG,
        ST_QMUL,
        ST_EXP,
        ST_CURVE,
        ST_SCALE,
        ST_FINISH
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Decode commands and next state
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.op       = DP_NOP;
        cmd.step     = cnt_reg;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (status.op == OP_SET)
                begin
                    cmd.op     = DP_WRITE;
                    state_next = ST_IDLE;
                end
                else if (!status.analog)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.pass)
                begin
                    cmd.op     = DP_PASS;
                    state_next = ST_FINISH;
                end
                else if (status.dead)
                begin
                    cmd.op     = DP_ZERO;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.op     = DP_SETUP;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.op   = DP_DIV;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (status.norm_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_LOG;
                end
                else
                begin
                    cmd.op = DP_NORM;
                end
            end
            ST_LOG:
            begin
                cmd.op   = DP_LOG;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(LOG_STEPS - 1))
                begin
                    state_next = ST_NLOG;
                end
            end
            ST_NLOG:
            begin
                cmd.op     = DP_NLOG;
                state_next = ST_QMUL;
            end
            ST_QMUL:
            begin
                cmd.op     = DP_QMUL;
                cnt_next   = '0;
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                cmd.op   = DP_EXP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(EXP_STEPS - 1))
                begin
                    state_next = ST_CURVE;
                end
            end
            ST_CURVE:
            begin
                cmd.op     = DP_CURVE;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.op     = DP_SCALE;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold state, counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    `AADC_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready, "result overwritten before taken")
    `AADC_ASSERT_NEXT(a_accept_prep, in_valid && in_ready, state_reg == ST_PREP, "accepted item not prepared")
    `AADC_ASSERT_NOW(a_div_bound, state_reg == ST_DIV, cnt_reg < 5'(DIV_STEPS), "divider step out of range")

endmodule

// ===== rtl/analog_axis_deadzone_curve_core.sv =====
// ---------------------------------------------------------------------------
// analog_axis_deadzone_curve_core
// Per-axis deadzone, response curve and gain for analog controller samples.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one item at a time. A set item writes the bias entry of its
//   axis and gives no result; a non-analog event is dropped. An analog event
//   gives one item on result: axis, raw sample and conditioned sample.
//   Pass-through and deadzone events set the result in the prepare state
//   and load it to the output from the finish state. A curved event runs
//   17 divider steps, up to 16 normalize shifts and a final check, 16 log
//   squarings and 16 exp multiplies, on one shared 32x32 multiplier and a
//   one-bit restoring divider.
//   The next item can be accepted in the cycle after the result is loaded;
//   cmd.ready is high only while no item is in work, so a new item is not
//   taken before the last one is through. Set and non-analog items return
//   to idle straight from the prepare state.
//   A finished result sits in the output register while the next item is
//   accepted and worked on; if the receiver stalls, the following result
//   waits in the datapath until the register is free.
//   Reset clears every axis entry (all axes pass raw) and empties the output.
// ---------------------------------------------------------------------------
module analog_axis_deadzone_curve_core
    import aadc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    aadc_in_if.sink    cmd,
    aadc_out_if.source result
);

    ctrl_cmd_t  ctl;
    dp_status_t st;

    aadc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (st),
        .cmd       (ctl)
    );

    aadc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (ctl),
        .status            (st),
        .op                (cmd.op),
        .axis_id           (cmd.axis_id),
        .is_analog         (cmd.is_analog),
        .raw_value         (cmd.raw_value),
        .deadzone_in       (cmd.deadzone_in),
        .exponent_in       (cmd.exponent_in),
        .sensitivity_in    (cmd.sensitivity_in),
        .invert_in         (cmd.invert_in),
        .axis_out          (result.axis_out),
        .raw_out           (result.raw_out),
        .conditioned_value (result.conditioned_value)
    );

endmodule

// ===== tb/analog_axis_deadzone_curve_core_tb.sv =====
// ---------------------------------------------------------------------------
// Axis conditioning block testbench
// Drives set items and raw axis events through the command channel, predicts
// each conditioned result with an independent fixed-point model, and checks
// every result item in order under random bursts, gaps and receiver stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module analog_axis_deadzone_curve_core_tb;
    import aadc_pkg::*;

    localparam int  N_RANDOM  = 650;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic               op;
        logic [3:0]         axis_id;
        logic               is_analog;
        logic signed [15:0] raw_value;
        logic [15:0]        deadzone_in;
        logic [15:0]        exponent_in;
        logic [15:0]        sensitivity_in;
        logic               invert_in;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0]         axis_out;
        logic signed [15:0] raw_out;
        logic signed [23:0] conditioned_value;
    } axis_result_t;

    // Directed row: item plus an optional hand-written expected value
    typedef struct packed {
        cmd_item_t  item;
        logic       has_cv;
        logic signed [23:0] cv;
    } dir_row_t;

    logic clk;
    logic rst_n;
    longint cycles;
    int     errors;
    bit     stim_done;

    aadc_in_if  cmd_ch();
    aadc_out_if res_ch();

    analog_axis_deadzone_curve_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch.sink),
        .result (res_ch.source)
    );

    // Predictor copy of the bias table
    logic        tbl_valid [AXIS_COUNT];
    logic [15:0] tbl_dz    [AXIS_COUNT];
    logic [15:0] tbl_exp   [AXIS_COUNT];
    logic [15:0] tbl_sens  [AXIS_COUNT];
    logic        tbl_inv   [AXIS_COUNT];

    axis_result_t pending_results [$];
    logic         row_check_cv [$];
    logic signed [23:0] row_cv [$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] acc;
        logic [63:0] rem;
        logic [63:0] b;
        acc = 0;
        rem = v;
        b   = 64'h4000_0000_0000_0000;
        while (b > rem && b != 0)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= acc + b)
            begin
                rem = rem - (acc + b);
                acc = (acc >> 1) + b;
            end
            else
                acc = acc >> 1;
            b = b >> 2;
        end
        return acc;
    endfunction

    function automatic logic [63:0] minus_log2(input logic [63:0] r);
        logic [63:0] k;
        logic [63:0] x;
        logic [63:0] f;
        k = 0;
        x = r;
        f = 0;
        while (x < 64'h10000)
        begin
            x = x << 1;
            k++;
        end
        for (int i = 1; i <= 16; i++)
        begin
            x = (x * x) >> 16;
            if (x >= 64'h20000)
            begin
                x = x >> 1;
                f = f | (64'd1 << (16 - i));
            end
        end
        return k * 65536 - f;
    endfunction

    function automatic logic [63:0] pow2_neg(input logic [63:0] q);
        logic [63:0] qi;
        logic [63:0] m;
        logic [63:0] c;
        qi = q >> 16;
        m  = 64'd1 << 30;
        c  = root64(64'd1 << 59);
        for (int i = 1; i <= 16; i++)
        begin
            if (q[16 - i])
                m = (m * c) >> 30;
            c = root64(c << 30);
        end
        if (qi + 14 >= 64)
            return 0;
        return m >> (14 + qi);
    endfunction

    function automatic logic signed [23:0] shape_sample(input logic signed [15:0] raw,
                                                        input int ax);
        longint v;
        logic [63:0] m;
        logic [63:0] dz;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] mag;
        bit neg;
        v   = tbl_inv[ax] ? -longint'(raw) : longint'(raw);
        neg = v < 0;
        m   = (neg ? -v : v) * 2;
        dz  = tbl_dz[ax];
        if (m <= dz)
            return 0;
        r   = ((m - dz) << 16) / (65536 - dz);
        q   = (64'(tbl_exp[ax]) * minus_log2(r)) >> 12;
        mag = (pow2_neg(q) * tbl_sens[ax]) >> 9;
        if (neg)
        begin
            if (mag > 8388608)
                mag = 8388608;
            return 24'(-longint'(mag));
        end
        if (mag > 8388607)
            mag = 8388607;
        return 24'(mag);
    endfunction

    // Advance the predictor by one accepted item
    task automatic predict_item(input cmd_item_t it, input logic chk, input logic [23:0] cv);
        axis_result_t res;
        int ax;
        ax = it.axis_id;
        if (it.op == OP_SET)
        begin
            tbl_valid[ax] = 1'b1;
            tbl_dz[ax]    = it.deadzone_in;
            tbl_exp[ax]   = it.exponent_in;
            tbl_sens[ax]  = it.sensitivity_in;
            tbl_inv[ax]   = it.invert_in;
        end
        else if (it.is_analog)
        begin
            res.axis_out = it.axis_id;
            res.raw_out  = it.raw_value;
            if (tbl_valid[ax])
                res.conditioned_value = shape_sample(it.raw_value, ax);
            else
                res.conditioned_value = 24'(it.raw_value);
            pending_results.push_back(res);
            row_check_cv.push_back(chk);
            row_cv.push_back(cv);
        end
    endtask

    function automatic cmd_item_t set_item(input int ax, input int dz, input int ex,
                                           input int sn, input bit inv);
        cmd_item_t it;
        it = $bits(cmd_item_t)'({$urandom, $urandom, $urandom});
        it.op = OP_SET;
        it.axis_id = 4'(ax);
        it.deadzone_in = 16'(dz);
        it.exponent_in = 16'(ex);
        it.sensitivity_in = 16'(sn);
        it.invert_in = inv;
        return it;
    endfunction

    function automatic cmd_item_t event_item(input int ax, input int raw, input bit an);
        cmd_item_t it;
        it = $bits(cmd_item_t)'({$urandom, $urandom, $urandom});
        it.op = OP_EVENT;
        it.axis_id = 4'(ax);
        it.is_analog = an;
        it.raw_value = 16'(raw);
        return it;
    endfunction

    function automatic cmd_item_t random_item(input bit wellformed);
        cmd_item_t it;
        int pick;
        it = $bits(cmd_item_t)'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 9);
        if (!wellformed)
            return it;
        if (pick < 2)
        begin
            it.op = OP_SET;
            // Modest, fully random or extreme settings
            case ($urandom_range(0, 3))
                0: it.deadzone_in = 16'($urandom_range(0, 8000));
                1: it.deadzone_in = 16'hFFFF - 16'($urandom_range(0, 3));
                default: it.deadzone_in = 16'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0)
                it.exponent_in = ($urandom_range(0, 1)) ? 16'h0 : 16'hFFFF;
            else
                it.exponent_in = 16'($urandom_range(1024, 16384));
            if ($urandom_range(0, 4) == 0)
                it.sensitivity_in = ($urandom_range(0, 1)) ? 16'h0 : 16'hFFFF;
        end
        else
        begin
            it.op = OP_EVENT;
            it.is_analog = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 5) == 0)
                it.raw_value = ($urandom_range(0, 1)) ? 16'sh7FFF : -16'sh8000;
        end
        return it;
    endfunction

    dir_row_t dir_rows [$];

    // Fill the directed table
    task automatic build_directed();
        dir_row_t row;
        row.has_cv = 0; row.cv = 0;
        // After reset every axis passes raw
        row.item = event_item(0, 32767, 1);   row.has_cv = 1; row.cv = 24'sd32767;
        dir_rows.push_back(row);
        row.item = event_item(15, -32768, 1); row.cv = -24'sd32768; dir_rows.push_back(row);
        row.item = event_item(3, 0, 1);       row.cv = 0; dir_rows.push_back(row);
        row.has_cv = 0;
        // Non-analog event gives nothing
        row.item = event_item(2, 1234, 0); dir_rows.push_back(row);
        // Exponent zero: curve is one, unity gain gives 1.0 out
        row.item = set_item(1, 0, 0, 256, 0); dir_rows.push_back(row);
        row.item = event_item(1, 100, 1); row.has_cv = 1; row.cv = 24'sd32768;
        dir_rows.push_back(row);
        row.item = event_item(1, -100, 1); row.cv = -24'sd32768; dir_rows.push_back(row);
        // At the deadzone edge, then outside it
        row.item = set_item(4, 40000, 4096, 256, 0); row.has_cv = 0; dir_rows.push_back(row);
        row.item = event_item(4, 20000, 1); row.has_cv = 1; row.cv = 0; dir_rows.push_back(row);
        row.item = event_item(4, 25000, 1); row.has_cv = 0; dir_rows.push_back(row);
        // Inversion, including negating the most negative sample
        row.item = set_item(5, 0, 4096, 256, 1); dir_rows.push_back(row);
        row.item = event_item(5, -32768, 1); dir_rows.push_back(row);
        row.item = event_item(5, 32767, 1); dir_rows.push_back(row);
        // Maximum gain on a unit curve lands just below full scale, zero gain gives zero
        row.item = set_item(6, 0, 0, 65535, 0); dir_rows.push_back(row);
        row.item = event_item(6, 5, 1); row.has_cv = 1; row.cv = 24'sd8388480;
        dir_rows.push_back(row);
        row.item = event_item(6, -5, 1); row.cv = -24'sd8388480; dir_rows.push_back(row);
        row.item = set_item(7, 0, 8192, 0, 0); row.has_cv = 0; dir_rows.push_back(row);
        row.item = event_item(7, 20000, 1); row.has_cv = 1; row.cv = 0; dir_rows.push_back(row);
        // Full deadzone swallows a full-scale sample; huge exponent and tiny sample shift the curve to zero
        row.item = set_item(8, 65535, 65535, 65535, 0); row.has_cv = 0; dir_rows.push_back(row);
        row.item = event_item(8, 32767, 1); dir_rows.push_back(row);
        row.item = set_item(8, 0, 65535, 65535, 0); dir_rows.push_back(row);
        row.item = event_item(8, 1, 1); dir_rows.push_back(row);
        // Replace an entry, then set ignores raw fields
        row.item = set_item(1, 1000, 2048, 512, 0); dir_rows.push_back(row);
        row.item = event_item(1, -16000, 1); dir_rows.push_back(row);
    endtask

    cmd_item_t stim_q [$];
    logic      stim_chk [$];
    logic [23:0] stim_cv [$];

    // Sender: bursts with random gaps
    initial
    begin
        int burst;
        int gap;
        cmd_ch.valid = 0;
        cmd_ch.op = OP_SET;
        cmd_ch.axis_id = 0;
        cmd_ch.is_analog = 0;
        cmd_ch.raw_value = 0;
        cmd_ch.deadzone_in = 0;
        cmd_ch.exponent_in = 0;
        cmd_ch.sensitivity_in = 0;
        cmd_ch.invert_in = 0;
        stim_done = 0;
        for (int a = 0; a < AXIS_COUNT; a++)
            tbl_valid[a] = 0;
        build_directed();
        foreach (dir_rows[i])
        begin
            stim_q.push_back(dir_rows[i].item);
            stim_chk.push_back(dir_rows[i].has_cv);
            stim_cv.push_back(dir_rows[i].cv);
        end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            stim_q.push_back(random_item($urandom_range(0, 9) != 0));
            stim_chk.push_back(0);
            stim_cv.push_back(0);
        end
        wait (rst_n === 1'b1);
        burst = 0;
        while (stim_q.size() > 0)
        begin
            @(negedge clk);
            if (burst == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 120);
                // Drop valid only when a real gap follows
                if (gap > 0)
                begin
                    cmd_ch.valid <= 0;
                    repeat (gap) @(negedge clk);
                end
                burst = $urandom_range(1, 12);
            end
            {cmd_ch.op, cmd_ch.axis_id, cmd_ch.is_analog, cmd_ch.raw_value,
             cmd_ch.deadzone_in, cmd_ch.exponent_in, cmd_ch.sensitivity_in,
             cmd_ch.invert_in} <= stim_q[0];
            cmd_ch.valid <= 1;
            // Hold until accepted
            do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
            predict_item(stim_q.pop_front(), stim_chk.pop_front(), stim_cv.pop_front());
            burst--;
        end
        @(negedge clk);
        cmd_ch.valid <= 0;
        stim_done = 1;
    end

    // Receiver: stall pattern of its own
    initial
    begin
        res_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            case ((cycles / 500) % 4)
                0: res_ch.ready <= 1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                2: res_ch.ready <= (cycles % 7 < 2);
                default: res_ch.ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        axis_result_t want;
        logic chk;
        logic [23:0] cv;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result axis=%0d", res_ch.axis_out);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                chk  = row_check_cv.pop_front();
                cv   = row_cv.pop_front();
                if (chk && cv !== want.conditioned_value)
                begin
                    $error("directed row conditioned_value: table %0d predictor %0d",
                           $signed(cv), want.conditioned_value);
                    errors++;
                end
                if (res_ch.axis_out !== want.axis_out)
                begin
                    $error("axis_out: expected %0d actual %0d", want.axis_out,
                           res_ch.axis_out);
                    errors++;
                end
                if (res_ch.raw_out !== want.raw_out)
                begin
                    $error("raw_out: expected %0d actual %0d", want.raw_out,
                           res_ch.raw_out);
                    errors++;
                end
                if (res_ch.conditioned_value !== want.conditioned_value)
                begin
                    $error("conditioned_value: expected %0d actual %0d",
                           want.conditioned_value, res_ch.conditioned_value);
                    errors++;
                end
            end
        end
    end

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Reset, then wait for drain
    initial
    begin
        errors = 0;
        cycles = 0;
        rst_n = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        wait (stim_done);
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
